### rtl/sprc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the servo PWM rate and compare setup block.
// Holds field widths, codes, the channel scale record and the microcode ROM.
package sprc_pkg;

	localparam int CH_W      = 4;
	localparam int BUS_W     = 2;
	localparam int RATE_W    = 16;
	localparam int POS_W     = 16;
	localparam int STATUS_W  = 2;
	localparam int PERIOD_W  = 32;
	localparam int PRESC_W   = 16;
	localparam int CMP_W     = 20;
	localparam int CFG_IDX_W = 2;
	localparam int CLK_W     = 28;
	localparam int TICK_W    = 24;
	localparam int SCALER_W  = 4;

	localparam int DIV_NUM_W  = 28;
	localparam int DIV_DEN_W  = 24;
	localparam int DIV_CYCLES = DIV_NUM_W / 2;
	localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

	localparam int UPC_W = 4;

	localparam logic [TICK_W-1:0]   BASE_TICK_HZ   = 24'd1000000;
	localparam logic [TICK_W-1:0]   HIRES_TICK_HZ  = 24'd12000000;
	localparam logic [RATE_W-1:0]   HIRES_MIN_RATE = 16'd500;
	localparam logic [PERIOD_W-1:0] PERIOD_NONE    = 32'hFFFF_FFFF;
	localparam logic [CLK_W-1:0]    SLOW_CLK_RESET = 28'd84000000;
	localparam logic [CLK_W-1:0]    FAST_CLK_RESET = 28'd168000000;

	localparam logic OP_RATE     = 1'b0;
	localparam logic OP_POSITION = 1'b1;

	localparam logic [BUS_W-1:0] BUS_SLOW = 2'd0;
	localparam logic [BUS_W-1:0] BUS_FAST = 2'd1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK          = 2'd0,
		ST_BAD_CHANNEL = 2'd1,
		ST_BAD_TIMER   = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CHANNELS_IN_USE = 2'd0,
		REG_HIRES_ENABLE    = 2'd1,
		REG_SLOW_BUS_CLK    = 2'd2,
		REG_FAST_BUS_CLK    = 2'd3
	} cfg_reg_t;

	// Per-channel record: hires flag, one-shot flag, halving scaler
	typedef struct packed {
		logic                hires;
		logic                oneshot;
		logic [SCALER_W-1:0] scaler;
	} scale_t;

	// Datapath actions, one per control word
	typedef enum logic [3:0] {
		A_NOP,
		A_LOAD,
		A_SETUP,
		A_SGROW,
		A_DIVP,
		A_CAPP,
		A_DIVQ,
		A_CAPQ,
		A_BARE,
		A_POS,
		A_ERR_CH,
		A_EMIT
	} act_t;

	// Jump conditions
	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_NOIN,
		C_BADCH,
		C_POS,
		C_RATE0,
		C_GROW,
		C_BUSY,
		C_BADBUS,
		C_OUTBLK
	} cond_t;

	typedef struct packed {
		act_t             act;
		cond_t            cond;
		logic [UPC_W-1:0] target;
	} uword_t;

	localparam logic [UPC_W-1:0] UPC_IDLE   = 4'd0;
	localparam logic [UPC_W-1:0] UPC_SETUP  = 4'd1;
	localparam logic [UPC_W-1:0] UPC_OPCHK  = 4'd2;
	localparam logic [UPC_W-1:0] UPC_RATE0  = 4'd3;
	localparam logic [UPC_W-1:0] UPC_GROW   = 4'd4;
	localparam logic [UPC_W-1:0] UPC_DIVP   = 4'd5;
	localparam logic [UPC_W-1:0] UPC_WAITP  = 4'd6;
	localparam logic [UPC_W-1:0] UPC_CAPP   = 4'd7;
	localparam logic [UPC_W-1:0] UPC_BUSCHK = 4'd8;
	localparam logic [UPC_W-1:0] UPC_DIVQ   = 4'd9;
	localparam logic [UPC_W-1:0] UPC_WAITQ  = 4'd10;
	localparam logic [UPC_W-1:0] UPC_CAPQ   = 4'd11;
	localparam logic [UPC_W-1:0] UPC_BARE   = 4'd12;
	localparam logic [UPC_W-1:0] UPC_POS    = 4'd13;
	localparam logic [UPC_W-1:0] UPC_ERRCH  = 4'd14;
	localparam logic [UPC_W-1:0] UPC_EMIT   = 4'd15;

	function automatic uword_t uw(input act_t a, input cond_t c, input logic [UPC_W-1:0] t);
		uword_t w;
		w.act    = a;
		w.cond   = c;
		w.target = t;
		return w;
	endfunction

	// Microprogram; a jump not taken advances to the next step, and the last
	// step wraps back to idle.
	function automatic uword_t ucode(input logic [UPC_W-1:0] step);
		uword_t w;
		case (step)
			UPC_IDLE:   w = uw(A_LOAD,   C_NOIN,   UPC_IDLE);
			UPC_SETUP:  w = uw(A_SETUP,  C_BADCH,  UPC_ERRCH);
			UPC_OPCHK:  w = uw(A_NOP,    C_POS,    UPC_POS);
			UPC_RATE0:  w = uw(A_NOP,    C_RATE0,  UPC_BUSCHK);
			UPC_GROW:   w = uw(A_SGROW,  C_GROW,   UPC_GROW);
			UPC_DIVP:   w = uw(A_DIVP,   C_NEVER,  UPC_IDLE);
			UPC_WAITP:  w = uw(A_NOP,    C_BUSY,   UPC_WAITP);
			UPC_CAPP:   w = uw(A_CAPP,   C_NEVER,  UPC_IDLE);
			UPC_BUSCHK: w = uw(A_NOP,    C_BADBUS, UPC_BARE);
			UPC_DIVQ:   w = uw(A_DIVQ,   C_NEVER,  UPC_IDLE);
			UPC_WAITQ:  w = uw(A_NOP,    C_BUSY,   UPC_WAITQ);
			UPC_CAPQ:   w = uw(A_CAPQ,   C_ALWAYS, UPC_EMIT);
			UPC_BARE:   w = uw(A_BARE,   C_ALWAYS, UPC_EMIT);
			UPC_POS:    w = uw(A_POS,    C_ALWAYS, UPC_EMIT);
			UPC_ERRCH:  w = uw(A_ERR_CH, C_NEVER,  UPC_IDLE);
			UPC_EMIT:   w = uw(A_EMIT,   C_OUTBLK, UPC_EMIT);
			default:    w = uw(A_NOP,    C_ALWAYS, UPC_IDLE);
		endcase
		return w;
	endfunction

endpackage

### rtl/sprc_item_if.sv
`timescale 1ns / 1ps
// Input item channel: valid/ready handshake with the rate/position request.
// Depends on sprc_pkg for field widths.
interface sprc_item_if;
	logic                          valid;
	logic                          ready;
	logic                          op;
	logic [sprc_pkg::CH_W-1:0]     channel;
	logic [sprc_pkg::BUS_W-1:0]    timer_bus;
	logic [sprc_pkg::RATE_W-1:0]   rate_hz;
	logic [sprc_pkg::POS_W-1:0]    position_us;

	modport source (output valid, op, channel, timer_bus, rate_hz, position_us, input ready);
	modport sink   (input valid, op, channel, timer_bus, rate_hz, position_us, output ready);
endinterface

### rtl/sprc_result_if.sv
`timescale 1ns / 1ps
// Result channel: valid/ready handshake with status, timer and compare values.
// Depends on sprc_pkg for field widths.
interface sprc_result_if;
	logic                          valid;
	logic                          ready;
	logic [sprc_pkg::STATUS_W-1:0] status;
	logic [sprc_pkg::PERIOD_W-1:0] period;
	logic [sprc_pkg::PRESC_W-1:0]  prescaler;
	logic [sprc_pkg::CMP_W-1:0]    compare;
	logic                          stop_timer;

	modport source (output valid, status, period, prescaler, compare, stop_timer, input ready);
	modport sink   (input valid, status, period, prescaler, compare, stop_timer, output ready);
endinterface

### rtl/sprc_cfg_if.sv
`timescale 1ns / 1ps
// Configuration write channel: valid/ready with register index and write data.
// Depends on sprc_pkg for field widths.
interface sprc_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [sprc_pkg::CFG_IDX_W-1:0] index;
	logic [sprc_pkg::CLK_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

### rtl/sprc_div.sv
`timescale 1ns / 1ps
// Iterative unsigned restoring divider, two quotient bits per cycle.
// Depends on sprc_pkg for operand widths and the iteration count.
module sprc_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [sprc_pkg::DIV_NUM_W-1:0]   num,
	input  logic [sprc_pkg::DIV_DEN_W-1:0]   den,
	output logic                             busy,
	output logic [sprc_pkg::DIV_NUM_W-1:0]   quo
);
	localparam int NW = sprc_pkg::DIV_NUM_W;
	localparam int DW = sprc_pkg::DIV_DEN_W;
	localparam logic [sprc_pkg::DIV_CNT_W-1:0] LAST_CNT =
		sprc_pkg::DIV_CNT_W'(sprc_pkg::DIV_CYCLES - 1);

	logic [DW:0]                       rem_q;
	logic [NW-1:0]                     quo_q;
	logic [DW-1:0]                     den_q;
	logic [sprc_pkg::DIV_CNT_W-1:0]    cnt_q;
	logic                              busy_q;
	logic [DW+NW:0]                    step1;
	logic [DW+NW:0]                    step2;

	// One shift-subtract step on {remainder, dividend/quotient}
	function automatic logic [DW+NW:0] div_step(input logic [DW:0] rem,
		input logic [NW-1:0] qv, input logic [DW-1:0] d);
		logic [DW:0] sh;
		logic        qbit;
		sh   = {rem[DW-1:0], qv[NW-1]};
		qbit = (sh >= {1'b0, d});
		if (qbit) begin
			sh = sh - {1'b0, d};
		end
		return {sh, qv[NW-2:0], qbit};
	endfunction

	assign step1 = div_step(rem_q, quo_q, den_q);
	assign step2 = div_step(step1[DW+NW:NW], step1[NW-1:0], den_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == LAST_CNT) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= step2[DW+NW:NW];
			quo_q <= step2[NW-1:0];
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;

endmodule

### rtl/servo_pwm_rate_and_compare_setup.sv
`timescale 1ns / 1ps
// Top level of the servo PWM rate and compare setup block.
// Depends on sprc_pkg, the three channel interfaces and sprc_div.

// A rate item (op 0) picks a 1 MHz tick, or 12 MHz when hires_enable is set
// and the rate is 0 or at least 500 Hz, raises a halving scaler, at most
// to MAX_SCALER, until the period fits 16 bits without overflowing the
// prescaler, records the scaler and flags for the channel, and returns
// period and prescaler. A position item (op 1) returns the compare value
// from the recorded flags and scaler. Control is a 16-step microprogram.
// The scaler search raises the scaler one step at a time, and the shared
// divider retires two quotient bits per cycle; a rate item uses it first
// for the period and then for the prescaler. A zero rate skips the search
// and the period divide, and an unusable timer skips the prescaler divide.
// A position item and a rejected channel go straight to their emit step.
// After the emit step the sequencer returns to idle, where it takes the
// next transfer. One item is worked at a time; the result sits in an output
// register, so the next item is taken while the previous result still waits
// for its transfer, and that next item holds at its emit step until the
// register frees. Configuration writes are always taken and must only come
// while the block is idle.
module servo_pwm_rate_and_compare_setup #(
	parameter int SERVO_CH_COUNT = 8,
	parameter int MAX_SCALER     = 15
) (
	input  logic        clk,
	input  logic        arst_n,
	sprc_cfg_if.sink    cfg,
	sprc_item_if.sink   req,
	sprc_result_if.source rsp
);
	localparam int IW = (SERVO_CH_COUNT > 1) ? $clog2(SERVO_CH_COUNT) : 1;
	localparam int CW = sprc_pkg::CH_W;
	localparam int TW = sprc_pkg::TICK_W;
	localparam int RW = sprc_pkg::RATE_W;
	localparam int KW = sprc_pkg::CLK_W;
	localparam int SW = sprc_pkg::SCALER_W;
	localparam int PW = sprc_pkg::PERIOD_W;
	localparam int HW = TW + 16;
	localparam logic [CW:0]   NCH_LIMIT  = (CW + 1)'(SERVO_CH_COUNT);
	localparam logic [SW-1:0] SCALER_TOP = SW'(MAX_SCALER);

	// Sequencer
	logic [sprc_pkg::UPC_W-1:0] upc_q;
	sprc_pkg::uword_t           cw;
	logic                       jump;

	// Configuration registers
	logic [CW-1:0] chans_q;
	logic          hires_en_q;
	logic [KW-1:0] slow_clk_q;
	logic [KW-1:0] fast_clk_q;

	// Latched item
	logic                        op_q;
	logic [CW-1:0]               ch_q;
	logic [sprc_pkg::BUS_W-1:0]  bus_q;
	logic [RW-1:0]               rate_q;
	logic [sprc_pkg::POS_W-1:0]  pos_q;

	// Working registers
	logic [SW-1:0] s_q;
	logic [TW-1:0] tsh_q;
	logic [KW-1:0] maxclk_q;
	logic          hires_q;
	logic          oneshot_q;

	// Result being built, and the output register
	logic [sprc_pkg::STATUS_W-1:0] res_status_q;
	logic [PW-1:0]                 res_period_q;
	logic [sprc_pkg::PRESC_W-1:0]  res_presc_q;
	logic [sprc_pkg::CMP_W-1:0]    res_cmp_q;
	logic                          res_stop_q;
	logic                          out_valid_q;
	logic [sprc_pkg::STATUS_W-1:0] out_status_q;
	logic [PW-1:0]                 out_period_q;
	logic [sprc_pkg::PRESC_W-1:0]  out_presc_q;
	logic [sprc_pkg::CMP_W-1:0]    out_cmp_q;
	logic                          out_stop_q;

	sprc_pkg::scale_t scale_q [SERVO_CH_COUNT];
	sprc_pkg::scale_t scale_rd;

	// Combinational helpers
	logic                         in_xfer;
	logic                         emit_fire;
	logic                         out_block;
	logic [CW:0]                  ch_limit;
	logic                         ch_ok;
	logic                         bad_bus;
	logic                         hires_sel;
	logic [PW-1:0]                rate_hi;
	logic [TW-1:0]                tsh_half;
	logic [HW-1:0]                half_hi;
	logic                         fits;
	logic                         pre_bad;
	logic                         grow;
	logic [IW-1:0]                ch_idx;
	logic [sprc_pkg::CMP_W-1:0]   pos_ext;
	logic [sprc_pkg::CMP_W-1:0]   pos_scaled;
	logic                         div_start;
	logic [sprc_pkg::DIV_NUM_W-1:0] div_num;
	logic [sprc_pkg::DIV_DEN_W-1:0] div_den;
	logic                         div_busy;
	logic [sprc_pkg::DIV_NUM_W-1:0] div_quo;
	logic [KW-1:0]                bus_clk;

	assign cw = sprc_pkg::ucode(upc_q);

	assign cfg.ready = 1'b1;
	assign req.ready = (cw.act == sprc_pkg::A_LOAD);
	assign in_xfer   = req.valid && req.ready;

	// Output register frees when its result transfers
	assign out_block = out_valid_q && !rsp.ready;
	assign emit_fire = (cw.act == sprc_pkg::A_EMIT) && !out_block;

	// Channel check: limit is the smaller of channels_in_use and the channel count
	assign ch_limit = ({1'b0, chans_q} > NCH_LIMIT) ? NCH_LIMIT : {1'b0, chans_q};
	assign ch_ok    = ({1'b0, ch_q} < ch_limit);
	assign ch_idx   = ch_q[IW-1:0];
	assign scale_rd = scale_q[ch_idx];

	assign bad_bus   = !(bus_q inside {sprc_pkg::BUS_SLOW, sprc_pkg::BUS_FAST});
	assign hires_sel = hires_en_q &&
		((rate_q == '0) || (rate_q >= sprc_pkg::HIRES_MIN_RATE));

	// Period fits 16 bits when 1 <= tick/rate <= 0x10000, that is
	// rate <= tick and tick < rate * 0x10001.
	assign rate_hi = {rate_q, 16'h0000} + PW'(rate_q);
	assign fits    = (tsh_q >= TW'(rate_q)) && (PW'(tsh_q) < rate_hi);

	// Next scaler step would overflow the prescaler when maxclk/(tick>>1)
	// is zero or above 0x10000.
	assign tsh_half = tsh_q >> 1;
	assign half_hi  = {tsh_half, 16'h0000} + HW'(tsh_half);
	assign pre_bad  = (maxclk_q < KW'(tsh_half)) || (HW'(maxclk_q) >= half_hi);
	assign grow     = !fits && (s_q < SCALER_TOP) && !pre_bad;

	// Position times 12 when the channel runs hires, then undo the scaler
	assign pos_ext    = {4'h0, pos_q};
	assign pos_scaled = scale_rd.hires ? ((pos_ext << 3) + (pos_ext << 2)) : pos_ext;

	assign bus_clk = (bus_q == sprc_pkg::BUS_FAST) ? fast_clk_q : slow_clk_q;

	// Shared divider: tick/rate for the period, bus clock/tick for the prescaler
	assign div_start = (cw.act == sprc_pkg::A_DIVP) || (cw.act == sprc_pkg::A_DIVQ);
	always_comb begin
		if (cw.act == sprc_pkg::A_DIVQ) begin
			div_num = bus_clk;
			div_den = tsh_q;
		end else begin
			div_num = sprc_pkg::DIV_NUM_W'(tsh_q);
			div_den = sprc_pkg::DIV_DEN_W'(rate_q);
		end
	end

	sprc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.quo    (div_quo)
	);

	// Jump decision for the current control word
	always_comb begin
		case (cw.cond)
			sprc_pkg::C_NEVER:  jump = 1'b0;
			sprc_pkg::C_ALWAYS: jump = 1'b1;
			sprc_pkg::C_NOIN:   jump = !req.valid;
			sprc_pkg::C_BADCH:  jump = !ch_ok;
			sprc_pkg::C_POS:    jump = (op_q == sprc_pkg::OP_POSITION);
			sprc_pkg::C_RATE0:  jump = (rate_q == '0);
			sprc_pkg::C_GROW:   jump = grow;
			sprc_pkg::C_BUSY:   jump = div_busy;
			sprc_pkg::C_BADBUS: jump = bad_bus;
			sprc_pkg::C_OUTBLK: jump = out_block;
			default:            jump = 1'b0;
		endcase
	end

	// Control state: step counter, output valid, configuration, channel records
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q       <= sprc_pkg::UPC_IDLE;
			out_valid_q <= 1'b0;
			chans_q     <= '0;
			hires_en_q  <= 1'b0;
			slow_clk_q  <= sprc_pkg::SLOW_CLK_RESET;
			fast_clk_q  <= sprc_pkg::FAST_CLK_RESET;
			for (int i = 0; i < SERVO_CH_COUNT; i++) begin
				scale_q[i] <= '0;
			end
		end else begin
			// advance, or take the jump
			upc_q <= jump ? cw.target : upc_q + 1'b1;

			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			if (cfg.valid && cfg.ready) begin
				case (sprc_pkg::cfg_reg_t'(cfg.index))
					sprc_pkg::REG_CHANNELS_IN_USE: chans_q    <= cfg.data[CW-1:0];
					sprc_pkg::REG_HIRES_ENABLE:    hires_en_q <= cfg.data[0];
					sprc_pkg::REG_SLOW_BUS_CLK:    slow_clk_q <= cfg.data;
					sprc_pkg::REG_FAST_BUS_CLK:    fast_clk_q <= cfg.data;
					default: ;
				endcase
			end

			// record the scaler: with flags on a usable timer, bare otherwise
			if (cw.act == sprc_pkg::A_CAPQ) begin
				scale_q[ch_idx] <= '{hires: hires_q, oneshot: oneshot_q, scaler: s_q};
			end else if (cw.act == sprc_pkg::A_BARE) begin
				scale_q[ch_idx] <= '{hires: 1'b0, oneshot: 1'b0, scaler: s_q};
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_q   <= req.op;
			ch_q   <= req.channel;
			bus_q  <= req.timer_bus;
			rate_q <= req.rate_hz;
			pos_q  <= req.position_us;
		end

		case (cw.act)
			sprc_pkg::A_SETUP: begin
				s_q          <= '0;
				tsh_q        <= hires_sel ? sprc_pkg::HIRES_TICK_HZ : sprc_pkg::BASE_TICK_HZ;
				maxclk_q     <= (slow_clk_q > fast_clk_q) ? slow_clk_q : fast_clk_q;
				hires_q      <= hires_sel;
				oneshot_q    <= hires_en_q && (rate_q == '0);
				res_status_q <= sprc_pkg::ST_OK;
				res_period_q <= sprc_pkg::PERIOD_NONE;
				res_presc_q  <= '0;
				res_cmp_q    <= '0;
				res_stop_q   <= 1'b0;
			end
			sprc_pkg::A_SGROW: begin
				if (grow) begin
					s_q   <= s_q + 1'b1;
					tsh_q <= tsh_half;
				end
			end
			sprc_pkg::A_CAPP: begin
				res_period_q <= PW'(div_quo) - 1'b1;
			end
			sprc_pkg::A_CAPQ: begin
				res_presc_q <= div_quo[sprc_pkg::PRESC_W-1:0] - 1'b1;
			end
			sprc_pkg::A_BARE: begin
				res_status_q <= sprc_pkg::ST_BAD_TIMER;
				res_period_q <= '0;
			end
			sprc_pkg::A_POS: begin
				res_period_q <= '0;
				res_cmp_q    <= pos_scaled >> scale_rd.scaler;
				res_stop_q   <= scale_rd.oneshot;
			end
			sprc_pkg::A_ERR_CH: begin
				res_status_q <= sprc_pkg::ST_BAD_CHANNEL;
				res_period_q <= '0;
			end
			default: ;
		endcase

		// hold the finished result for its transfer
		if (emit_fire) begin
			out_status_q <= res_status_q;
			out_period_q <= res_period_q;
			out_presc_q  <= res_presc_q;
			out_cmp_q    <= res_cmp_q;
			out_stop_q   <= res_stop_q;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = out_status_q;
	assign rsp.period     = out_period_q;
	assign rsp.prescaler  = out_presc_q;
	assign rsp.compare    = out_cmp_q;
	assign rsp.stop_timer = out_stop_q;

endmodule
